### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/pfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the page allocator.
package pfa_pkg;

  // Default sizing
  localparam int MAX_PAGES_DEF  = 4096;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int ADDR_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int REFV_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] FIRST_USABLE_RESET = 32'd0;
  localparam logic [ADDR_W-1:0] TOP_ADDR_RESET     = 32'd16777216;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ADDR     = 2'd1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_INIT_FREE = 3'd2;
  localparam logic [OP_W-1:0] OP_INCR      = 3'd3;
  localparam logic [OP_W-1:0] OP_DECR      = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTONE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;    // clearing pass: zero one count entry
    logic capture;  // take the item, launch memory reads
    logic exec;     // apply the operation, write back, load result
  } pfa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last; // clearing pass is at its final entry
  } pfa_sts_t;

endpackage

### rtl/pfa_ctrl.sv
// Controller state machine: clearing pass, idle and execute states.
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pfa_pkg::pfa_sts_t sts,
  output pfa_pkg::pfa_cmd_t cmd
);
  import pfa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  assign busy        = (state != S_IDLE);
  assign cmd.clear   = (state == S_CLEAR);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.exec    = (state == S_EXEC);

endmodule

### rtl/pfa_datapath.sv
// Datapath: config registers, free-list head, link and count memories, result registers.
module pfa_datapath #(
  parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pfa_pkg::pfa_cmd_t               cmd,
  output pfa_pkg::pfa_sts_t               sts,
  input  logic [pfa_pkg::OP_W-1:0]        opcode,
  input  logic [pfa_pkg::ADDR_W-1:0]      page_addr,
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]      cfg_data,
  output logic                            done,
  output logic [pfa_pkg::STATUS_W-1:0]    status,
  output logic [pfa_pkg::ADDR_W-1:0]      alloc_addr,
  output logic [pfa_pkg::REFV_W-1:0]      ref_value
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(MAX_PAGES - 1);
  localparam logic [ADDR_W-1:0]     PAGES_LIM = ADDR_W'(MAX_PAGES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  // Configuration registers
  logic [ADDR_W-1:0] first_usable;
  logic [ADDR_W-1:0] top_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= FIRST_USABLE_RESET;
      top_addr     <= TOP_ADDR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIRST_USABLE) first_usable <= cfg_data;
      if (cfg_index == CFG_TOP_ADDR)     top_addr     <= cfg_data;
    end
  end

  // Free-list head
  logic [IDX_W-1:0] free_head;
  logic             head_valid;

  // Captured item
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode;
      addr_r <= page_addr;
    end
  end

  // Index of the incoming and captured address
  logic [ADDR_W-1:0] in_shift;
  logic [ADDR_W-1:0] r_shift;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  r_idx;

  assign in_shift = page_addr >> PAGE_SHIFT;
  assign r_shift  = addr_r >> PAGE_SHIFT;
  assign in_idx   = in_shift[IDX_W-1:0];
  assign r_idx    = r_shift[IDX_W-1:0];

  // Clearing pass counter
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  assign sts.clr_last = (clr_idx == LAST_IDX);

  // Count memory and link memory
  logic [COUNT_BITS-1:0] cnt_mem [MAX_PAGES];
  logic [IDX_W:0]        nxt_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IDX_W:0]        nxt_rd;
  logic [IDX_W-1:0]      cnt_raddr;

  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  nxt_we;

  assign cnt_raddr = (opcode == OP_ALLOC) ? free_head : in_idx;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.capture) cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[r_idx] <= {head_valid, free_head};
    if (cmd.capture) nxt_rd <= nxt_mem[free_head];
  end

  // Address checks on the captured item
  logic addr_good;
  logic idx_in_range;

  assign idx_in_range = (r_shift < PAGES_LIM);
  assign addr_good = (addr_r[PAGE_SHIFT-1:0] == '0) && (addr_r >= first_usable) &&
                     (addr_r < top_addr) && idx_in_range;

  // Allocated address, resized to the address width
  logic [IDX_W+PAGE_SHIFT-1:0] head_addr_full;
  assign head_addr_full = {free_head, {PAGE_SHIFT{1'b0}}};

  // Operation logic
  logic [STATUS_W-1:0]   status_next;
  logic [ADDR_W-1:0]     alloc_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  push;
  logic                  pop;

  always_comb begin
    status_next = ST_OK;
    alloc_next  = '0;
    count_next  = '0;
    push        = 1'b0;
    pop         = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = r_idx;
    cnt_wdata   = cnt_rd;
    case (op_r)
      OP_ALLOC: begin
        if (!head_valid) begin
          status_next = ST_OOM;
        end else begin
          pop        = 1'b1;
          alloc_next = ADDR_W'(head_addr_full);
          count_next = CNT_ONE;
          cnt_we     = 1'b1;
          cnt_waddr  = free_head;
          cnt_wdata  = CNT_ONE;
        end
      end
      OP_FREE: begin
        if (!addr_good) begin
          status_next = ST_BADADDR;
        end else begin
          count_next = cnt_rd;
          if (cnt_rd != CNT_ONE) status_next = ST_NOTONE;
          else push = 1'b1;
        end
      end
      OP_INIT_FREE: begin
        if (!addr_good) begin
          status_next = ST_BADADDR;
        end else begin
          count_next = cnt_rd;
          push       = 1'b1;
        end
      end
      OP_INCR: begin
        if (!addr_good) begin
          status_next = ST_BADADDR;
        end else if (cnt_rd == CNT_MAX) begin
          status_next = ST_LIMIT;
          count_next  = cnt_rd;
        end else begin
          count_next = cnt_rd + CNT_ONE;
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_rd + CNT_ONE;
        end
      end
      OP_DECR: begin
        if (!addr_good) begin
          status_next = ST_BADADDR;
        end else if (cnt_rd == '0) begin
          status_next = ST_LIMIT;
          count_next  = cnt_rd;
        end else begin
          count_next = cnt_rd - CNT_ONE;
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_rd - CNT_ONE;
        end
      end
      OP_READ: begin
        if (!idx_in_range) status_next = ST_BADADDR;
        else count_next = cnt_rd;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // only apply writes in the execute cycle; clearing pass owns the port otherwise
    if (!cmd.exec) begin
      push      = 1'b0;
      pop       = 1'b0;
      cnt_we    = cmd.clear;
      cnt_waddr = clr_idx;
      cnt_wdata = '0;
    end
  end

  assign nxt_we = push;

  // Head update on push and pop
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      free_head  <= '0;
    end else if (push) begin
      head_valid <= 1'b1;
      free_head  <= r_idx;
    end else if (pop) begin
      head_valid <= nxt_rd[IDX_W];
      free_head  <= nxt_rd[IDX_W-1:0];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= status_next;
      alloc_addr <= alloc_next;
      ref_value  <= REFV_W'(count_next);
    end
  end

endmodule

### rtl/page_frame_allocator_refcount_core.sv
// Top level of the page-frame allocator with reference counts.
//
//  channel   signals                                   transfer when
//  -------   ---------------------------------------   ---------------------
//  command   start, busy, opcode, page_addr            start && !busy
//  result    done, status, alloc_addr, ref_value       done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// For each item, the accept edge launches the count and link
// memory reads, the next cycle applies the operation and writes back.
// The result shows in the cycle after that, while the next item may be accepted.
// After reset a clearing pass zeroes the count memory with busy high;
// config writes are taken at all times (cfg_ready is tied high).
// The result receiver cannot stall; each result is valid for one cycle only.
module page_frame_allocator_refcount_core #(
  parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pfa_pkg::OP_W-1:0]      opcode,
  input  logic [pfa_pkg::ADDR_W-1:0]    page_addr,
  output logic                          done,
  output logic [pfa_pkg::STATUS_W-1:0]  status,
  output logic [pfa_pkg::ADDR_W-1:0]    alloc_addr,
  output logic [pfa_pkg::REFV_W-1:0]    ref_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]    cfg_data
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  assign cfg_ready = 1'b1;

  // Controller
  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath
  pfa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .page_addr  (page_addr),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .alloc_addr (alloc_addr),
    .ref_value  (ref_value)
  );

endmodule

### rtl/pfa_checker.sv
// Port-level checker for the page allocator, bound to the top level.
`include "assert_macros.svh"

module pfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [pfa_pkg::STATUS_W-1:0] status,
  input logic [pfa_pkg::ADDR_W-1:0]   alloc_addr,
  input logic [pfa_pkg::REFV_W-1:0]   ref_value
);
  import pfa_pkg::*;

  // a result never shows while the block is busy
  `ASSERT_IMP(a_done_idle, clk, rst, done, !busy)

  // an accepted command is being worked on next cycle, with no result yet
  `ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

  // out of memory and bad address give zero address and zero count
  `ASSERT_IMP(a_err_zero, clk, rst, done && (status == ST_OOM || status == ST_BADADDR),
              alloc_addr == '0 && ref_value == '0)

  // only allocate gives a nonzero address, and then count one
  `ASSERT_IMP(a_alloc_one, clk, rst, done && alloc_addr != '0,
              status == ST_OK && ref_value == REFV_W'(1))

endmodule

bind page_frame_allocator_refcount_core pfa_checker u_pfa_checker (.*);
